FILE: rtl/core/ufq_pkg.sv
package ufq_pkg;

   localparam int VALUE_W  = 31;
   localparam int STATUS_W = 3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEGATIVE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef struct packed {
      logic               op;
      logic signed [31:0] data_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  data_out;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/unique_fifo_queue.sv
// Channel     Ports                         Transfer
// request     start, busy, req_data         rising edge with start high and busy low
// result      rsp_strobe, rsp_data          the single cycle in which rsp_strobe is high
//
// A remove, or an insert of a negative value, gives its result in the cycle after the transfer.
// An insert of a non-negative value rotates the row of cells once round in S_SCAN, to
// compare every held value, then commits in S_DONE, whose result is registered onto rsp_data.
// Synchronous reset empties the queue; the stored values themselves are not cleared.
// The receiver cannot stall; busy holds further requests off while an insert is being checked.
module unique_fifo_queue #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ufq_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output ufq_pkg::rsp_type  rsp_data
);
   import ufq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(DEPTH - 1);

   logic [1:0]         state_ff,  state_in;
   logic [CNT_W-1:0]   fill_ff,   fill_in;
   logic [CNT_W-1:0]   cnt_ff,    cnt_in;
   logic               found_ff,  found_in;
   logic [VALUE_W-1:0] value_ff,  value_in;
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff,    rsp_in;

   logic                 shift_all;
   logic                 load_any;
   logic [VALUE_W-1:0]   cell_data [DEPTH];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         localparam logic [CNT_W-1:0] POS = CNT_W'(i);
         cell_ctrl_type      ctrl;
         logic [VALUE_W-1:0] next_value;

         always_comb begin
            ctrl.shift = shift_all;
            ctrl.load  = load_any && (fill_ff == POS);
         end

         assign next_value = (i == DEPTH - 1) ? cell_data[0] : cell_data[(i + 1) % DEPTH];

         ufq_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .next_data (next_value),
            .load_data (value_ff),
            .data      (cell_data[i])
         );
      end
   endgenerate

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      found_in  = found_ff;
      value_in  = value_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      shift_all = 1'b0;
      load_any  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in.data_out = '0;
               if (req_data.op == OP_REMOVE) begin
                  strobe_in = 1'b1;
                  if (fill_ff == '0) begin
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     rsp_in.status   = ST_OK;
                     rsp_in.data_out = cell_data[0];
                     shift_all       = 1'b1;
                     fill_in         = fill_ff - CNT_W'(1);
                  end
               end else if (req_data.data_in[31]) begin
                  strobe_in     = 1'b1;
                  rsp_in.status = ST_NEGATIVE;
               end else begin
                  value_in = req_data.data_in[VALUE_W-1:0];
                  cnt_in   = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            shift_all = 1'b1;
            if ((cnt_ff < fill_ff) && (cell_data[0] == value_ff)) begin
               found_in = 1'b1;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            strobe_in       = 1'b1;
            state_in        = S_IDLE;
            rsp_in.data_out = '0;
            priority if (found_ff) begin
               rsp_in.status = ST_DUPLICATE;
            end else if (fill_ff == FULL_COUNT) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status   = ST_OK;
               rsp_in.data_out = value_ff;
               load_any        = 1'b1;
               fill_in         = fill_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      found_ff <= found_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: rtl/core/ufq_cell.sv
module ufq_cell (
   input  logic                         clock,
   input  ufq_pkg::cell_ctrl_type       ctrl,
   input  logic [ufq_pkg::VALUE_W-1:0]  next_data,
   input  logic [ufq_pkg::VALUE_W-1:0]  load_data,
   output logic [ufq_pkg::VALUE_W-1:0]  data
);
   import ufq_pkg::*;

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;

   always_comb begin
      priority if (ctrl.load) begin
         data_in = load_data;
      end else if (ctrl.shift) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: sim/tb_unique_fifo_queue.sv
module tb_unique_fifo_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import ufq_pkg::*;

   localparam int QDEPTH = 16;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   unique_fifo_queue #(.DEPTH(QDEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the queue contents.
   logic [VALUE_W-1:0] ring [QDEPTH];
   logic [3:0]         head = '0;
   logic [4:0]         fill = '0;

   req_type     outgoing_ops [$];
   rsp_type     awaited_replies [$];
   int unsigned sender_idle_pct = 0;
   int unsigned mismatches = 0;
   int unsigned transfers = 0;
   int unsigned replies_checked = 0;
   int unsigned removes_ok = 0;
   int unsigned outcome_count [5] = '{default: 0};

   function automatic rsp_type queue_reply(req_type item);
      rsp_type            reply;
      logic [VALUE_W-1:0] value;
      logic               found;
      int                 k;
      reply.status   = ST_OK;
      reply.data_out = '0;
      value = item.data_in[VALUE_W-1:0];
      if (item.op == OP_INSERT) begin
         found = 1'b0;
         for (k = 0; k < int'(fill); k++) begin
            if (ring[(int'(head) + k) % QDEPTH] == value) begin
               found = 1'b1;
            end
         end
         if (item.data_in[31]) begin
            reply.status = ST_NEGATIVE;
         end else if (found) begin
            reply.status = ST_DUPLICATE;
         end else if (int'(fill) >= QDEPTH) begin
            reply.status = ST_FULL;
         end else begin
            ring[(int'(head) + int'(fill)) % QDEPTH] = value;
            fill = fill + 5'd1;
            reply.data_out = value;
         end
      end else begin
         if (fill == '0) begin
            reply.status = ST_EMPTY;
         end else begin
            reply.data_out = ring[head];
            head = head + 4'd1;
            fill = fill - 5'd1;
            removes_ok++;
         end
      end
      outcome_count[reply.status]++;
      return reply;
   endfunction

   // Driver: holds an item until its transfer, then may idle before the next one.
   always @(posedge clock) begin : drive_requests
      logic    taken;
      req_type upcoming;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            awaited_replies.push_back(queue_reply(req_data));
            transfers++;
         end
         if (start && !taken) begin
            // The current request is still waiting for its transfer.
         end else if (outgoing_ops.size() != 0 &&
                      $urandom_range(0, 99) >= sender_idle_pct) begin
            upcoming = outgoing_ops.pop_front();
            req_data <= upcoming;
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch_replies
      rsp_type wanted;
      if (!reset && rsp_strobe) begin
         if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected result status %0d data %0h", $time,
                     rsp_data.status, rsp_data.data_out);
            mismatches++;
         end else begin
            wanted = awaited_replies.pop_front();
            replies_checked++;
            if (rsp_data.status !== wanted.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                        wanted.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.data_out !== wanted.data_out) begin
               $display("%0t: data_out mismatch, expected %0h, actual %0h", $time,
                        wanted.data_out, rsp_data.data_out);
               mismatches++;
            end
         end
      end
   end

   task automatic add_op(logic op, logic [31:0] value);
      req_type item;
      item.op      = op;
      item.data_in = value;
      outgoing_ops.push_back(item);
   endtask

   function automatic logic [31:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         return $urandom_range(0, 47);
      end else if (sel < 85) begin
         return $urandom() & 32'h7FFF_FFFF;
      end else if (sel < 95) begin
         return $urandom();
      end else if (sel < 97) begin
         return 32'h0000_0000;
      end
      return 32'h7FFF_FFFF;
   endfunction

   // Bursts that lean towards inserts fill the queue; the others drain it.
   task automatic add_random_ops(int count);
      int          left;
      int          burst;
      int unsigned insert_pct;
      left = count;
      while (left > 0) begin
         burst      = $urandom_range(1, 24);
         insert_pct = $urandom_range(0, 1) ? 80 : 25;
         while (burst > 0 && left > 0) begin
            if ($urandom_range(0, 99) < insert_pct) begin
               add_op(OP_INSERT, pick_value());
            end else begin
               add_op(OP_REMOVE, $urandom());
            end
            burst--;
            left--;
         end
      end
   endtask

   task automatic wait_until_settled();
      do begin
         @(negedge clock);
      end while (outgoing_ops.size() != 0 || start || awaited_replies.size() != 0);
   endtask

   initial begin : run_sequence
      int k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_op(OP_REMOVE, 32'hFFFF_FFFF);
      add_op(OP_INSERT, 32'h8000_0000);
      add_op(OP_INSERT, 32'hFFFF_FFFF);
      add_op(OP_INSERT, 32'h0000_0000);
      add_op(OP_INSERT, 32'h0000_0000);
      add_op(OP_INSERT, 32'h7FFF_FFFF);
      for (k = 1; k <= QDEPTH - 2; k++) begin
         add_op(OP_INSERT, k * 37 + 1);
      end
      add_op(OP_INSERT, 32'd5000);
      add_op(OP_INSERT, 32'h7FFF_FFFF);
      add_op(OP_REMOVE, 32'hFFFF_FFFF);
      wait_until_settled();

      sender_idle_pct = 26;
      add_random_ops(250);
      wait_until_settled();

      sender_idle_pct = 50;
      add_random_ops(250);
      wait_until_settled();

      sender_idle_pct = 0;
      add_random_ops(250);
      wait_until_settled();

      repeat (QDEPTH + 8) @(posedge clock);
      $display("Checked %0d results from %0d transfers: %0d inserts stored, %0d removes served.",
               replies_checked, transfers, outcome_count[ST_OK] - removes_ok, removes_ok);
      $display("Rejections seen: %0d negative, %0d duplicate, %0d full, %0d empty.",
               outcome_count[ST_NEGATIVE], outcome_count[ST_DUPLICATE],
               outcome_count[ST_FULL], outcome_count[ST_EMPTY]);
      if (mismatches == 0 && awaited_replies.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Run timed out.");
      $display("status: fail");
      $finish;
   end

endmodule
